// ===== src/phase_angle_dimmer_control_macros.svh =====
// ----------------------------------------------------------------------------
// phase_angle_dimmer_control_macros
// assertion macros for the dimmer control block, empty when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef PHASE_ANGLE_DIMMER_CONTROL_MACROS_SVH
`define PHASE_ANGLE_DIMMER_CONTROL_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked on every rising clock edge outside reset
`define PAD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define PAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PAD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/pad_pkg.sv =====
// ----------------------------------------------------------------------------
// pad_pkg
// shared types and constants of the phase-angle dimmer control block
// ----------------------------------------------------------------------------
package pad_pkg;

   // event codes carried in the kind field
   localparam logic [2:0] KIND_ZERO_CROSS = 3'd0;
   localparam logic [2:0] KIND_TICK       = 3'd1;
   localparam logic [2:0] KIND_UP         = 3'd2;
   localparam logic [2:0] KIND_DOWN       = 3'd3;
   localparam logic [2:0] KIND_IDLE       = 3'd4;
   localparam logic [2:0] KIND_ADC        = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_GATE_THRESHOLD     = 3'd0;
   localparam logic [2:0] CSR_PULSE_RELOAD       = 3'd1;
   localparam logic [2:0] CSR_TOP_STEP           = 3'd2;
   localparam logic [2:0] CSR_UP_TAP_LIMIT       = 3'd3;
   localparam logic [2:0] CSR_DOWN_TAP_LIMIT     = 3'd4;
   localparam logic [2:0] CSR_ANALOG_FLOOR       = 3'd5;
   localparam logic [2:0] CSR_ANALOG_FLOOR_LEVEL = 3'd6;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 8;

   // reset values of the configuration registers
   localparam logic [7:0] RST_GATE_THRESHOLD     = 8'd40;
   localparam logic [7:0] RST_PULSE_RELOAD       = 8'hfa;
   localparam logic [5:0] RST_TOP_STEP           = 6'd51;
   localparam logic [3:0] RST_UP_TAP_LIMIT       = 4'd5;
   localparam logic [3:0] RST_DOWN_TAP_LIMIT     = 4'd7;
   localparam logic [7:0] RST_ANALOG_FLOOR       = 8'd10;
   localparam logic [7:0] RST_ANALOG_FLOOR_LEVEL = 8'h05;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_DELAY = 2'd1,
      PHASE_PULSE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       released;
      logic [7:0] adc_value;
   } req_type;

   typedef struct packed {
      logic       gate_on;
      logic       green_lit;
      logic       red_lit;
      logic [7:0] drive_level;
   } rsp_type;

   // which button-side event this transaction is
   typedef struct packed {
      logic up;
      logic down;
      logic idle;
      logic released;
   } btn_cmd_type;

   typedef struct packed {
      logic [5:0] top_step;
      logic [3:0] up_tap_limit;
      logic [3:0] down_tap_limit;
   } btn_cfg_type;

   typedef struct packed {
      logic [7:0] step_index;
      logic [7:0] press_start;
      logic       up_held;
      logic       down_held;
      logic [7:0] remembered;
      logic       remember_enable;
      logic       green_lit;
      logic       red_lit;
   } btn_state_type;

endpackage

// ===== src/phase_angle_dimmer_control.sv =====
// a transaction accepted into the input register is processed by the combinational state update
// and written to the result register, which drives rsp_, once that register is free or draining
// throughput: one transaction per cycle while rsp_ready stays high, set by the combinational
// state update between the input register and the result register
// reset: synchronous, active high; resets the valid flags and block state and loads the register reset values
// ----------------------------------------------------------------------------
// phase_angle_dimmer_control
// thyristor phase-angle dimmer: zero-cross timed gate pulse, button ramp with
// tap recall and memory, and analog level input
// ----------------------------------------------------------------------------
`include "phase_angle_dimmer_control_macros.svh"

module phase_angle_dimmer_control #(
   parameter int unsigned TIMER_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input transactions
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pad_pkg::req_type                     req_data,
   // result transactions
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pad_pkg::rsp_type                     rsp_data,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [pad_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pad_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import pad_pkg::*;

   // configuration registers
   logic [7:0] gate_threshold_ff;
   logic [7:0] pulse_reload_ff;
   logic [5:0] top_step_ff;
   logic [3:0] up_tap_limit_ff;
   logic [3:0] down_tap_limit_ff;
   logic [7:0] analog_floor_ff;
   logic [7:0] analog_floor_level_ff;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // block state
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   phase_type             phase_ff, phase_in;
   logic [7:0]            level_ff, level_in;
   logic                  gate_ff, gate_in;
   btn_state_type         btn_ff, btn_in;

   // button unit hookup
   btn_cmd_type btn_cmd;
   btn_cfg_type btn_cfg;
   logic        btn_level_load;
   logic [7:0]  btn_level;

   logic                  fire;
   logic [TIMER_BITS-1:0] timer_inc;

   // ---------------------------------------------------------------------------
   // handshake: the input register drains whenever the result register is free
   // or being emptied in the same cycle, so both sides stream at full rate
   // ---------------------------------------------------------------------------
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------------------
   // configuration writes, indexes past the list are ignored
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_threshold_ff     <= RST_GATE_THRESHOLD;
         pulse_reload_ff       <= RST_PULSE_RELOAD;
         top_step_ff           <= RST_TOP_STEP;
         up_tap_limit_ff       <= RST_UP_TAP_LIMIT;
         down_tap_limit_ff     <= RST_DOWN_TAP_LIMIT;
         analog_floor_ff       <= RST_ANALOG_FLOOR;
         analog_floor_level_ff <= RST_ANALOG_FLOOR_LEVEL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GATE_THRESHOLD:     gate_threshold_ff     <= csr_wdata;
            CSR_PULSE_RELOAD:       pulse_reload_ff       <= csr_wdata;
            CSR_TOP_STEP:           top_step_ff           <= csr_wdata[5:0];
            CSR_UP_TAP_LIMIT:       up_tap_limit_ff       <= csr_wdata[3:0];
            CSR_DOWN_TAP_LIMIT:     down_tap_limit_ff     <= csr_wdata[3:0];
            CSR_ANALOG_FLOOR:       analog_floor_ff       <= csr_wdata;
            CSR_ANALOG_FLOOR_LEVEL: analog_floor_level_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // button side: step index, taps, remembered level and end leds
   // ---------------------------------------------------------------------------
   assign btn_cmd.up       = (in_data_ff.kind == KIND_UP);
   assign btn_cmd.down     = (in_data_ff.kind == KIND_DOWN);
   assign btn_cmd.idle     = (in_data_ff.kind == KIND_IDLE);
   assign btn_cmd.released = in_data_ff.released;

   assign btn_cfg.top_step       = top_step_ff;
   assign btn_cfg.up_tap_limit   = up_tap_limit_ff;
   assign btn_cfg.down_tap_limit = down_tap_limit_ff;

   pad_button u_button (
      .cmd         (btn_cmd),
      .cfg         (btn_cfg),
      .cur         (btn_ff),
      .nxt         (btn_in),
      .level_load  (btn_level_load),
      .level_value (btn_level)
   );

   // ---------------------------------------------------------------------------
   // gate timing: zero cross arms the delay, the first overflow fires the gate when the level
   // exceeds the threshold and loads the pulse width, the second overflow ends the pulse
   // ---------------------------------------------------------------------------
   assign timer_inc = timer_ff + TIMER_BITS'(1);

   always_comb begin
      timer_in = timer_ff;
      phase_in = phase_ff;
      gate_in  = gate_ff;
      level_in = level_ff;
      case (in_data_ff.kind)
         KIND_ZERO_CROSS: begin
            // re-arming drops any overflow still pending from the last half cycle
            timer_in = TIMER_BITS'(level_ff);
            phase_in = PHASE_DELAY;
         end
         KIND_TICK: begin
            timer_in = timer_inc;
            if (timer_inc == '0) begin
               case (phase_ff)
                  PHASE_DELAY: begin
                     gate_in  = (level_ff > gate_threshold_ff);
                     timer_in = TIMER_BITS'(pulse_reload_ff);
                     phase_in = PHASE_PULSE;
                  end
                  PHASE_PULSE: begin
                     gate_in  = 1'b0;
                     phase_in = PHASE_IDLE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         KIND_ADC: begin
            // analog input with a floor
            level_in = (in_data_ff.adc_value < analog_floor_ff) ? analog_floor_level_ff
                                                                : in_data_ff.adc_value;
         end
         default: begin
            if (btn_level_load) begin
               level_in = btn_level;
            end
         end
      endcase

      // result reflects the state after this transaction
      rsp_data_in.gate_on     = gate_in;
      rsp_data_in.green_lit   = btn_in.green_lit;
      rsp_data_in.red_lit     = btn_in.red_lit;
      rsp_data_in.drive_level = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         phase_ff <= PHASE_IDLE;
         level_ff <= 8'd0;
         gate_ff  <= 1'b0;
         btn_ff   <= '{step_index: 8'd1, default: '0};
      end else if (fire) begin
         timer_ff <= timer_in;
         phase_ff <= phase_in;
         level_ff <= level_in;
         gate_ff  <= gate_in;
         btn_ff   <= btn_in;
      end
   end

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   // the gate is only ever driven inside an armed half cycle
   `PAD_ASSERT_NOW(a_gate_needs_phase, clock, reset, gate_ff, phase_ff != PHASE_IDLE, "gate on while idle")
   // a held input transaction is not lost while the result side stalls
   `PAD_ASSERT_NEXT(a_stall_keeps_input, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_ready, in_valid_ff, "input dropped under stall")
   // the two end leds never light together
   `PAD_ASSERT_NOW(a_leds_exclusive, clock, reset, btn_ff.green_lit, !btn_ff.red_lit, "both end leds lit")

endmodule

// ===== src/pad_button.sv =====
// ----------------------------------------------------------------------------
// pad_button
// next-state logic of the brightness step index, taps, memory and end leds
// ----------------------------------------------------------------------------
module pad_button (
   input  pad_pkg::btn_cmd_type   cmd,
   input  pad_pkg::btn_cfg_type   cfg,
   input  pad_pkg::btn_state_type cur,
   output pad_pkg::btn_state_type nxt,
   output logic                   level_load,
   output logic [7:0]             level_value
);
   import pad_pkg::*;

   logic [7:0]        up_start;
   logic [7:0]        up_inc;
   logic signed [9:0] up_diff;
   logic [7:0]        up_sel;
   logic              up_clamp;
   logic [7:0]        up_idx;

   logic [7:0]        dn_start;
   logic signed [9:0] dn_diff;
   logic              dn_tap;
   logic [7:0]        dn_sel;
   logic              dn_clamp;
   logic [7:0]        dn_idx;

   logic [7:0]        new_idx;
   logic [9:0]        scaled;

   // up path
   assign up_start = cur.up_held ? cur.press_start : cur.step_index;
   assign up_inc   = cur.step_index + 8'd1;
   assign up_diff  = $signed({2'b00, up_inc}) - $signed({2'b00, up_start});
   assign up_sel   = (cmd.released && (up_diff < $signed({6'd0, cfg.up_tap_limit})))
                     ? cur.remembered : up_inc;
   assign up_clamp = (up_sel >= {2'b00, cfg.top_step});
   assign up_idx   = up_clamp ? {2'b00, cfg.top_step} : up_sel;

   // down path
   assign dn_start = cur.down_held ? cur.press_start : cur.step_index;
   assign dn_diff  = $signed({2'b00, dn_start}) - $signed({2'b00, cur.step_index});
   assign dn_tap   = cmd.released && (dn_diff < $signed({6'd0, cfg.down_tap_limit}));
   assign dn_sel   = dn_tap ? 8'd0 : (cur.step_index - 8'd1);
   assign dn_clamp = (dn_sel <= 8'd1);
   assign dn_idx   = dn_clamp ? 8'd1 : dn_sel;

   // level is index times five, kept to eight bits
   assign new_idx     = cmd.up ? up_idx : dn_idx;
   assign scaled      = {new_idx, 2'b00} + {2'b00, new_idx};
   assign level_value = scaled[7:0];
   assign level_load  = cmd.up | cmd.down;

   always_comb begin
      nxt = cur;
      if (cmd.up) begin
         nxt.step_index      = up_idx;
         nxt.press_start     = up_start;
         nxt.up_held         = !cmd.released;
         nxt.remember_enable = 1'b1;
         nxt.green_lit       = up_clamp;
         nxt.red_lit         = 1'b0;
      end else if (cmd.down) begin
         nxt.step_index  = dn_idx;
         nxt.press_start = dn_start;
         nxt.down_held   = !cmd.released;
         if (dn_tap) begin
            nxt.remember_enable = 1'b0;
         end
         nxt.green_lit = 1'b0;
         nxt.red_lit   = dn_clamp;
      end else if (cmd.idle && cur.remember_enable) begin
         nxt.remembered = cur.step_index;
      end
   end

endmodule

// ===== test/phase_angle_dimmer_control_tb.sv =====
// ----------------------------------------------------------------------------
// phase_angle_dimmer_control_tb
// self-checking bench for the dimmer control block: a directed table, then
// random gate-pulse, button-ramp and analog sequences under several register
// settings, each result checked against a hand-typed value or a cycle-free model of the block
// ----------------------------------------------------------------------------
module phase_angle_dimmer_control_tb;
   import pad_pkg::*;

   localparam int unsigned TIMER_WIDTH = 8;
   localparam int unsigned CYCLE_LIMIT = 200000;
   // the two kind codes the block ignores
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;
   // items per random phase
   localparam int unsigned PHASE_ITEMS = 75;
   localparam int unsigned PHASE_COUNT = 7;
   localparam int unsigned PLAN_ROWS   = 25;

   typedef struct packed {
      logic [7:0] gate_threshold;
      logic [7:0] pulse_reload;
      logic [7:0] top_step;
      logic [7:0] up_tap_limit;
      logic [7:0] down_tap_limit;
      logic [7:0] analog_floor;
      logic [7:0] analog_floor_level;
   } settings_type;

   // one directed row: the transaction, and a hand-typed result where typed is set
   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // register copies held by the model
   logic [7:0] cfg_gate_threshold     = RST_GATE_THRESHOLD;
   logic [7:0] cfg_pulse_reload       = RST_PULSE_RELOAD;
   logic [5:0] cfg_top_step           = RST_TOP_STEP;
   logic [3:0] cfg_up_tap_limit       = RST_UP_TAP_LIMIT;
   logic [3:0] cfg_down_tap_limit     = RST_DOWN_TAP_LIMIT;
   logic [7:0] cfg_analog_floor       = RST_ANALOG_FLOOR;
   logic [7:0] cfg_analog_floor_level = RST_ANALOG_FLOOR_LEVEL;

   // model state, at its reset values
   logic [TIMER_WIDTH-1:0] delay_timer = '0;
   phase_type  timer_phase     = PHASE_IDLE;
   logic [7:0] drive_level_q   = 8'd0;
   logic [7:0] step_index      = 8'd1;
   logic [7:0] press_start     = 8'd0;
   logic       up_held         = 1'b0;
   logic       down_held       = 1'b0;
   logic [7:0] remembered      = 8'd0;
   logic       remember_enable = 1'b0;
   logic       gate_q          = 1'b0;
   logic       green_q         = 1'b0;
   logic       red_q           = 1'b0;

   rsp_type     pending_rsp[$];
   int unsigned fails          = 0;
   int unsigned items_sent     = 0;
   int unsigned rsp_count      = 0;
   int unsigned cycle_count    = 0;
   int unsigned off_cnt        = 0;
   bit          long_hold_done = 1'b0;
   // no idling on either side once set
   bit          quiet          = 1'b0;

   // directed table: reset state, adc extremes and floor edge, ignored kinds,
   // a full gate pulse, button taps to min and restore, and a zero cross
   row_type plan [PLAN_ROWS] = '{
      '{'{KIND_IDLE,       1'b0, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00}},
      '{'{KIND_ADC,        1'b0, 8'hff}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'hff}},
      '{'{KIND_ADC,        1'b0, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h05}},
      '{'{KIND_ADC,        1'b0, 8'h09}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h05}},
      '{'{KIND_ADC,        1'b0, 8'h0a}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h0a}},
      '{'{KIND_SPARE_LO,   1'b1, 8'haa}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h0a}},
      '{'{KIND_SPARE_HI,   1'b0, 8'h55}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h0a}},
      '{'{KIND_ADC,        1'b1, 8'hff}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'hff}},
      '{'{KIND_ZERO_CROSS, 1'b0, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'hff}},
      '{'{KIND_TICK,       1'b1, 8'hff}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'hff}},
      '{'{KIND_TICK,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_TICK,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_TICK,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_TICK,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_TICK,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_TICK,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_TICK,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_UP,         1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_UP,         1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_UP,         1'b1, 8'h00}, 1'b0, '0},
      '{'{KIND_DOWN,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_DOWN,       1'b1, 8'h00}, 1'b0, '0},
      '{'{KIND_IDLE,       1'b0, 8'h00}, 1'b0, '0},
      '{'{KIND_ZERO_CROSS, 1'b1, 8'h00}, 1'b0, '0},
      '{'{KIND_ADC,        1'b1, 8'h80}, 1'b0, '0}
   };

   phase_angle_dimmer_control #(
      .TIMER_BITS(TIMER_WIDTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // model of one transaction: update the state, report the outputs after it
   task automatic dimmer_step(input req_type r, output rsp_type o);
      int span;
      case (r.kind)
         KIND_ZERO_CROSS: begin
            // reload from the level, any pending overflow is gone
            delay_timer = drive_level_q;
            timer_phase = PHASE_DELAY;
         end
         KIND_TICK: begin
            delay_timer = delay_timer + 1'b1;
            if (delay_timer == '0) begin
               if (timer_phase == PHASE_DELAY) begin
                  gate_q      = (drive_level_q > cfg_gate_threshold);
                  delay_timer = cfg_pulse_reload;
                  timer_phase = PHASE_PULSE;
               end else if (timer_phase == PHASE_PULSE) begin
                  gate_q      = 1'b0;
                  timer_phase = PHASE_IDLE;
               end
            end
         end
         KIND_UP: begin
            if (!up_held) begin
               press_start = step_index;
               up_held     = 1'b1;
            end
            step_index = step_index + 1'b1;
            span = int'(step_index) - int'(press_start);
            // short tap restores the remembered step
            if (r.released && span < int'(cfg_up_tap_limit)) step_index = remembered;
            if (step_index >= {2'b00, cfg_top_step}) begin
               step_index = {2'b00, cfg_top_step};
               green_q    = 1'b1;
            end else begin
               green_q = 1'b0;
            end
            red_q = 1'b0;
            if (r.released) up_held = 1'b0;
            remember_enable = 1'b1;
            drive_level_q   = step_index * 8'd5;
         end
         KIND_DOWN: begin
            if (!down_held) begin
               press_start = step_index;
               down_held   = 1'b1;
            end
            span = int'(press_start) - int'(step_index);
            // short tap drops to minimum and stops the memory
            if (r.released && span < int'(cfg_down_tap_limit)) begin
               step_index      = 8'd0;
               remember_enable = 1'b0;
            end else begin
               step_index = step_index - 1'b1;
            end
            if (step_index <= 8'd1) begin
               step_index = 8'd1;
               red_q      = 1'b1;
            end else begin
               red_q = 1'b0;
            end
            green_q = 1'b0;
            if (r.released) down_held = 1'b0;
            drive_level_q = step_index * 8'd5;
         end
         KIND_IDLE: begin
            if (remember_enable) remembered = step_index;
         end
         KIND_ADC: begin
            drive_level_q = (r.adc_value < cfg_analog_floor) ? cfg_analog_floor_level
                                                             : r.adc_value;
         end
         default: ;
      endcase
      o.gate_on     = gate_q;
      o.green_lit   = green_q;
      o.red_lit     = red_q;
      o.drive_level = drive_level_q;
   endtask

   // offer one transaction, wait for its handshake, then record its result
   task automatic send_txn(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type want;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      dimmer_step(r, want);
      pending_rsp.push_back(typed ? typed_rsp : want);
      items_sent++;
   endtask

   task automatic offer(input logic [2:0] k, input logic rel, input logic [7:0] adc);
      req_type r;
      r.kind      = k;
      r.released  = rel;
      r.adc_value = adc;
      send_txn(r, 1'b0, '0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_GATE_THRESHOLD:     cfg_gate_threshold     = val;
         CSR_PULSE_RELOAD:       cfg_pulse_reload       = val;
         CSR_TOP_STEP:           cfg_top_step           = val[5:0];
         CSR_UP_TAP_LIMIT:       cfg_up_tap_limit       = val[3:0];
         CSR_DOWN_TAP_LIMIT:     cfg_down_tap_limit     = val[3:0];
         CSR_ANALOG_FLOOR:       cfg_analog_floor       = val;
         CSR_ANALOG_FLOOR_LEVEL: cfg_analog_floor_level = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic apply_settings(input settings_type s);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      // margin before the configuration writes
      repeat (4) @(posedge clock);
      write_csr(CSR_GATE_THRESHOLD,     s.gate_threshold);
      write_csr(CSR_PULSE_RELOAD,       s.pulse_reload);
      write_csr(CSR_TOP_STEP,           s.top_step);
      write_csr(CSR_UP_TAP_LIMIT,       s.up_tap_limit);
      write_csr(CSR_DOWN_TAP_LIMIT,     s.down_tap_limit);
      write_csr(CSR_ANALOG_FLOOR,       s.analog_floor);
      write_csr(CSR_ANALOG_FLOOR_LEVEL, s.analog_floor_level);
      csr_we <= 1'b0;
   endtask

   // random sequences until the item count reaches target
   task automatic run_random_phase(input int unsigned target);
      int       n;
      int       i;
      logic [2:0] k;
      while (items_sent < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // gate pulse: at times a high level, then a zero cross and a run of ticks toward both
               // overflows; a stray zero cross now and then drops the pending one
               if ($urandom_range(0, 1)) offer(KIND_ADC, 1'($urandom_range(0, 1)),
                                               8'($urandom_range(176, 255)));
               offer(KIND_ZERO_CROSS, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               n = $urandom_range(1, 90);
               for (i = 0; i < n; i++) begin
                  if ($urandom_range(0, 49) == 0) begin
                     offer(KIND_ZERO_CROSS, 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
                  end else begin
                     offer(KIND_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                  end
               end
            end
            4, 5, 6: begin
               // button press: held steps ending in a release, short ones are taps;
               // now and then the release is left out
               n = $urandom_range(1, 16);
               k = $urandom_range(0, 1) ? KIND_UP : KIND_DOWN;
               for (i = 1; i <= n; i++) begin
                  offer(k, (i == n) ? ($urandom_range(0, 7) != 0) : 1'b0,
                        8'($urandom_range(0, 255)));
               end
               if ($urandom_range(0, 1)) offer(KIND_IDLE, 1'($urandom_range(0, 1)),
                                               8'($urandom_range(0, 255)));
            end
            7: offer(KIND_IDLE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            8: offer(KIND_ADC, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            default: offer(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // result side: check each transaction, then pick ready for the next edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (pending_rsp.size() == 0) begin
               $error("result transaction with nothing expected");
               fails++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.gate_on !== want.gate_on) begin
                  $error("gate_on: expected %0d, got %0d", want.gate_on, rsp_data.gate_on);
                  fails++;
               end
               if (rsp_data.green_lit !== want.green_lit) begin
                  $error("green_lit: expected %0d, got %0d", want.green_lit,
                         rsp_data.green_lit);
                  fails++;
               end
               if (rsp_data.red_lit !== want.red_lit) begin
                  $error("red_lit: expected %0d, got %0d", want.red_lit, rsp_data.red_lit);
                  fails++;
               end
               if (rsp_data.drive_level !== want.drive_level) begin
                  $error("drive_level: expected %0d, got %0d", want.drive_level,
                         rsp_data.drive_level);
                  fails++;
               end
            end
         end
         if (off_cnt != 0) begin
            rsp_ready <= 1'b0;
            off_cnt   <= off_cnt - 1;
         end else if (!long_hold_done && rsp_count >= 150) begin
            // one long hold-off so the pipeline fills and req_ready drops
            long_hold_done <= 1'b1;
            off_cnt        <= 79;
            rsp_ready      <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            off_cnt   <= $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      settings_type s;
      int           i;
      int unsigned  p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table under the reset register values
      for (i = 0; i < PLAN_ROWS; i++) begin
         send_txn(plan[i].req, plan[i].typed, plan[i].rsp);
      end

      for (p = 0; p < PHASE_COUNT; p++) begin
         s.gate_threshold     = 8'($urandom_range(0, 255));
         s.pulse_reload       = 8'($urandom_range(0, 255));
         s.top_step           = 8'($urandom_range(1, 51));
         s.up_tap_limit       = 8'($urandom_range(0, 15));
         s.down_tap_limit     = 8'($urandom_range(0, 15));
         s.analog_floor       = 8'($urandom_range(0, 255));
         s.analog_floor_level = 8'($urandom_range(0, 255));
         case (p)
            0: s = '{RST_GATE_THRESHOLD, RST_PULSE_RELOAD, {2'b00, RST_TOP_STEP},
                     {4'h0, RST_UP_TAP_LIMIT}, {4'h0, RST_DOWN_TAP_LIMIT},
                     RST_ANALOG_FLOOR, RST_ANALOG_FLOOR_LEVEL};
            // all registers at their lowest, top step at one
            1: s = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0};
            // all registers at their highest, top step at 51
            2: s = '{8'd255, 8'd255, 8'd51, 8'd15, 8'd15, 8'd255, 8'd255};
            // top step of zero clamps the index to zero on up
            4: begin
               s.top_step     = 8'd0;
               s.pulse_reload = 8'($urandom_range(240, 255));
            end
            // top step above full brightness lets the level wrap
            5: begin
               s.top_step     = 8'd63;
               s.pulse_reload = 8'($urandom_range(224, 255));
            end
            default: ;
         endcase
         apply_settings(s);
         if (p == PHASE_COUNT - 1) quiet = 1'b1;
         run_random_phase(PLAN_ROWS + (p + 1) * PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
